// ===== hdl/pipt_pkg.sv =====
// Shared types and constants for the point-in-polygon test block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pipt_pkg;

  // Operation carried by an item.
  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2
  } action_e;

  // Code returned with every result.
  typedef enum logic [2:0] {
    RES_OUTSIDE  = 3'd0,
    RES_INSIDE   = 3'd1,
    RES_BOUNDARY = 3'd2,
    RES_STORED   = 3'd3,
    RES_FULL     = 3'd4,
    RES_CLEARED  = 3'd5
  } result_e;

  // Fewest vertices that still make a polygon.
  localparam int unsigned MIN_VERTICES = 3;

  // Width of the reported vertex count.
  localparam int unsigned COUNT_OUT_W = 7;

  // Query token that travels down the cell chain.
  typedef struct packed {
    logic valid;  // token present in this stage
    logic bnd;    // point found on a vertex or an edge
    logic par;    // even-odd crossing parity
  } tok_ctl_t;

endpackage

// ===== hdl/pipt_cell.sv =====
// One cell of the polygon chain: holds one vertex and tests the query point
// against the edge from the previous vertex to it. Depends on pipt_pkg.
`timescale 1ns / 1ps

module pipt_cell import pipt_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic signed [COORD_BITS-1:0] wr_x_i,
  input  logic signed [COORD_BITS-1:0] wr_y_i,
  input  logic                         active_i,
  input  logic signed [COORD_BITS-1:0] px_i,
  input  logic signed [COORD_BITS-1:0] py_i,
  input  tok_ctl_t                     ctl_i,
  input  logic signed [COORD_BITS-1:0] prev_x_i,
  input  logic signed [COORD_BITS-1:0] prev_y_i,
  output tok_ctl_t                     ctl_o,
  output logic signed [COORD_BITS-1:0] prev_x_o,
  output logic signed [COORD_BITS-1:0] prev_y_o
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;

  logic signed [COORD_BITS-1:0] vx_q, vy_q;
  logic signed [COORD_BITS-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  tok_ctl_t                     ctl_q, ctl_d;

  logic signed [DW-1:0] dx, dy, ex, ey;
  logic signed [PW-1:0] p_cross, p_run;
  logic signed [COORD_BITS-1:0] lo_x, hi_x, lo_y, hi_y;
  logic on_vtx, in_box, on_edge, straddle, dy_pos, left, toggle;

  // Edge runs from the previous vertex (j) to this cell's vertex (i).
  assign dx = DW'(prev_x_i) - DW'(vx_q);
  assign dy = DW'(prev_y_i) - DW'(vy_q);
  assign ex = DW'(px_i) - DW'(vx_q);
  assign ey = DW'(py_i) - DW'(vy_q);

  // dx*(py-yi) against dy*(px-xi): equality means collinear, and the
  // sign of the difference says which side of the edge the point is on.
  assign p_cross = PW'(dx) * PW'(ey);
  assign p_run   = PW'(dy) * PW'(ex);

  assign lo_x = (vx_q < prev_x_i) ? vx_q : prev_x_i;
  assign hi_x = (vx_q < prev_x_i) ? prev_x_i : vx_q;
  assign lo_y = (vy_q < prev_y_i) ? vy_q : prev_y_i;
  assign hi_y = (vy_q < prev_y_i) ? prev_y_i : vy_q;

  assign on_vtx   = (px_i == vx_q) && (py_i == vy_q);
  assign in_box   = (px_i >= lo_x) && (px_i <= hi_x) && (py_i >= lo_y) && (py_i <= hi_y);
  assign on_edge  = (p_cross == p_run) && in_box;
  // A straddling edge always has a nonzero dy, so zero-length edges drop out.
  assign straddle = (vy_q > py_i) != (prev_y_i > py_i);
  assign dy_pos   = !dy[DW-1] && (dy != '0);
  assign left     = dy_pos ? (p_run < p_cross) : (p_run > p_cross);
  assign toggle   = straddle && left;

  always_comb begin
    ctl_d    = ctl_i;
    prev_x_d = prev_x_i;
    prev_y_d = prev_y_i;
    if (ctl_i.valid && active_i) begin
      ctl_d.bnd = ctl_i.bnd | on_vtx | on_edge;
      ctl_d.par = ctl_i.par ^ toggle;
      prev_x_d  = vx_q;
      prev_y_d  = vy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_x_q <= prev_x_d;
    prev_y_q <= prev_y_d;
    if (wr_en_i) begin
      vx_q <= wr_x_i;
      vy_q <= wr_y_i;
    end
  end

  assign ctl_o    = ctl_q;
  assign prev_x_o = prev_x_q;
  assign prev_y_o = prev_y_q;

endmodule

// ===== hdl/point_in_polygon_test.sv =====
// Top level of the point-in-polygon test: vertex count, command decode and
// a chain of pipt_cell instances. Depends on pipt_pkg and pipt_cell.
`timescale 1ns / 1ps

// The block keeps a polygon of up to MAX_VERTICES vertices and answers
// even-odd point-in-polygon queries on it. An item is taken at a rising edge
// where start is high and busy is low, and every item produces exactly one
// result, shown for a single cycle with done_o high; the receiver cannot
// stall, so it must capture the result in that cycle. Clear, append and the
// unused action answer in the cycle right after the item is taken. A query
// on fewer than three vertices also answers in the next cycle with the
// boundary code. Any other query passes through the launch register, each
// cell of the chain and the result register before its result is shown,
// and it holds the block until then: the point is launched into a chain of
// MAX_VERTICES cells, one vertex per cell, and the token moves one cell per
// clock, each cell testing one edge. Busy stays high during that time, and
// it drops in the cycle in which the result is shown, so a new item can be
// taken at the edge that ends the strobe. A point on a vertex or on an edge
// reports boundary, and zero-length edges are ignored. An append to a full
// store is refused with the store-full code. Clear only resets the count;
// stored vertices are simply overwritten by later appends. The vertex
// storage has no reset, which is safe because only entries below the count
// are ever used.
module point_in_polygon_test import pipt_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   action_i,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  output logic                         done_o,
  output logic [2:0]                   result_code_o,
  output logic [COUNT_OUT_W-1:0]       vertex_count_o
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  logic                         accept;
  logic [CNT_W-1:0]             count_q, count_d;
  logic                         busy_q, busy_d;
  logic                         launch_q, launch_d;
  logic                         done_q, done_d;
  result_e                      code_q, code_d;
  logic                         store_full, append_ok;
  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic signed [COORD_BITS-1:0] last_x_q, last_y_q;

  // Chain links: index k feeds cell k, index MAX_VERTICES is the chain end.
  tok_ctl_t                     link_ctl [MAX_VERTICES+1];
  logic signed [COORD_BITS-1:0] link_px  [MAX_VERTICES+1];
  logic signed [COORD_BITS-1:0] link_py  [MAX_VERTICES+1];

  assign accept     = start && !busy_q;
  assign store_full = (count_q == CNT_W'(MAX_VERTICES));
  assign append_ok  = accept && (action_i == ACT_APPEND) && !store_full;

  // Command decode and result selection.
  always_comb begin
    count_d  = count_q;
    busy_d   = busy_q;
    launch_d = 1'b0;
    done_d   = 1'b0;
    code_d   = code_q;
    if (accept) begin
      unique case (action_i)
        ACT_CLEAR: begin
          count_d = '0;
          done_d  = 1'b1;
          code_d  = RES_CLEARED;
        end
        ACT_APPEND: begin
          done_d = 1'b1;
          if (store_full) begin
            code_d = RES_FULL;
          end else begin
            count_d = count_q + CNT_W'(1);
            code_d  = RES_STORED;
          end
        end
        ACT_QUERY: begin
          if (count_q < CNT_W'(MIN_VERTICES)) begin
            done_d = 1'b1;
            code_d = RES_BOUNDARY;
          end else begin
            launch_d = 1'b1;
            busy_d   = 1'b1;
          end
        end
        default: begin
          done_d = 1'b1;
          code_d = RES_BOUNDARY;
        end
      endcase
    end else if (link_ctl[MAX_VERTICES].valid) begin
      // The query token has left the last cell.
      busy_d = 1'b0;
      done_d = 1'b1;
      priority if (link_ctl[MAX_VERTICES].bnd) begin
        code_d = RES_BOUNDARY;
      end else if (link_ctl[MAX_VERTICES].par) begin
        code_d = RES_INSIDE;
      end else begin
        code_d = RES_OUTSIDE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      busy_q   <= 1'b0;
      launch_q <= 1'b0;
      done_q   <= 1'b0;
      code_q   <= RES_OUTSIDE;
    end else begin
      count_q  <= count_d;
      busy_q   <= busy_d;
      launch_q <= launch_d;
      done_q   <= done_d;
      code_q   <= code_d;
    end
  end

  // Query point and the most recent vertex, which closes the polygon.
  always_ff @(posedge clk_i) begin
    if (accept && (action_i == ACT_QUERY)) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
    end
    if (append_ok) begin
      last_x_q <= coord_x_i;
      last_y_q <= coord_y_i;
    end
  end

  // The token enters cell 0 with the last vertex as its previous vertex, so
  // cell 0 tests the closing edge.
  assign link_ctl[0] = '{valid: launch_q, bnd: 1'b0, par: 1'b0};
  assign link_px[0]  = last_x_q;
  assign link_py[0]  = last_y_q;

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    logic wr_en, active;

    assign wr_en  = append_ok && (count_q == CNT_W'(k));
    assign active = (count_q > CNT_W'(k));

    pipt_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_en_i  (wr_en),
      .wr_x_i   (coord_x_i),
      .wr_y_i   (coord_y_i),
      .active_i (active),
      .px_i     (px_q),
      .py_i     (py_q),
      .ctl_i    (link_ctl[k]),
      .prev_x_i (link_px[k]),
      .prev_y_i (link_py[k]),
      .ctl_o    (link_ctl[k+1]),
      .prev_x_o (link_px[k+1]),
      .prev_y_o (link_py[k+1])
    );
  end

  assign busy           = busy_q;
  assign done_o         = done_q;
  assign result_code_o  = code_q;
  assign vertex_count_o = COUNT_OUT_W'(count_q);

endmodule

// ===== hdl/pipt_checker.sv =====
// Port-level checks for point_in_polygon_test, bound to the top level.
// Depends on pipt_pkg.
`timescale 1ns / 1ps

module pipt_port_checks import pipt_pkg::*; (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic [1:0]                   action_i,
  input logic                         done_o,
  input logic [2:0]                   result_code_o,
  input logic [COUNT_OUT_W-1:0]       vertex_count_o
);

  // A result is never shown while a query is still in the chain.
  a_no_done_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !done_o)
    else $error("result shown while busy");

  // A clear answers in the next cycle with the cleared code and a zero count.
  a_clear_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (action_i == ACT_CLEAR)) |=>
      (done_o && (result_code_o == RES_CLEARED) && (vertex_count_o == '0)))
    else $error("clear not answered in the next cycle");

  // An append is answered in the next cycle, stored or refused.
  a_append_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (action_i == ACT_APPEND)) |=>
      (done_o && ((result_code_o == RES_STORED) || (result_code_o == RES_FULL))))
    else $error("append not answered in the next cycle");

  // A stored vertex always leaves a nonzero count.
  a_stored_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_code_o == RES_STORED)) |-> (vertex_count_o != '0))
    else $error("vertex stored but count is zero");

endmodule

bind point_in_polygon_test pipt_port_checks u_pipt_port_checks (.*);

// ===== test/pipt_checker.sv =====
// Scoreboard for the point-in-polygon test block: watches the item and result channels,
// predicts every result from its own polygon store and compares it field by field.
// Depends on pipt_pkg.
`timescale 1ns / 1ps

module pipt_checker import pipt_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [1:0]                   action_i,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  input  logic                         done_i,
  input  logic [2:0]                   result_code_i,
  input  logic [COUNT_OUT_W-1:0]       vertex_count_i,
  output int                           mismatch_count_o,
  output int                           pending_o
);

  typedef struct {
    result_e                code;
    logic [COUNT_OUT_W-1:0] count;
  } outcome_t;

  outcome_t results_due[$];

  longint poly_x[MAX_VERTICES];
  longint poly_y[MAX_VERTICES];
  int     held       = 0;
  int     mismatches = 0;

  assign mismatch_count_o = mismatches;

  task automatic flag_mismatch(input string what);
    if (mismatches < 100) begin
      $display("[%0t] pipt_checker: %s", $time, what);
    end
    mismatches++;
  endtask

  // Even-odd crossing test of a point against the held polygon, closing edge included.
  // All products fit easily in 64 bits, so the compares are exact.
  function automatic result_e locate_point(input longint px, input longint py);
    longint xi, yi, xj, yj, dx, dy, lhs, rhs;
    bit     odd;
    int     i, j;
    odd = 1'b0;
    if (held < MIN_VERTICES) return RES_BOUNDARY;
    for (i = 0; i < held; i++) begin
      j  = (i == 0) ? held - 1 : i - 1;
      xi = poly_x[i];
      yi = poly_y[i];
      xj = poly_x[j];
      yj = poly_y[j];
      dx = xj - xi;
      dy = yj - yi;
      if (px == xi && py == yi) return RES_BOUNDARY;
      if (dx * (py - yi) == dy * (px - xi) &&
          px >= ((xi < xj) ? xi : xj) && px <= ((xi < xj) ? xj : xi) &&
          py >= ((yi < yj) ? yi : yj) && py <= ((yi < yj) ? yj : yi)) begin
        return RES_BOUNDARY;
      end
      if (dx == 0 && dy == 0) continue;
      if ((yi > py) != (yj > py)) begin
        lhs = (px - xi) * dy;
        rhs = dx * (py - yi);
        if ((dy > 0) ? (lhs < rhs) : (lhs > rhs)) odd = !odd;
      end
    end
    return odd ? RES_INSIDE : RES_OUTSIDE;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t due;
    outcome_t fresh;
    if (!rst_ni) begin
      held = 0;
      results_due.delete();
      pending_o <= 0;
    end else begin
      // The result leaving at this edge belongs to an older item, so it is checked
      // before an item taken at the same edge is predicted.
      if ($isunknown(done_i)) begin
        flag_mismatch("done strobe is unknown");
      end else if (done_i) begin
        if (results_due.size() == 0) begin
          flag_mismatch($sformatf("result code %0d count %0d with no item outstanding",
                                  result_code_i, vertex_count_i));
        end else begin
          due = results_due.pop_front();
          if (result_code_i !== due.code) begin
            flag_mismatch($sformatf("result code %0d, predicted %0d (%s)",
                                    result_code_i, due.code, due.code.name()));
          end
          if (vertex_count_i !== due.count) begin
            flag_mismatch($sformatf("vertex count %0d, predicted %0d",
                                    vertex_count_i, due.count));
          end
        end
      end
      if (start_i && $isunknown(busy_i)) begin
        flag_mismatch("busy is unknown while an item is offered");
      end
      if (start_i && !busy_i) begin
        case (action_i)
          ACT_CLEAR: begin
            held       = 0;
            fresh.code = RES_CLEARED;
          end
          ACT_APPEND: begin
            if (held >= MAX_VERTICES) begin
              fresh.code = RES_FULL;
            end else begin
              poly_x[held] = longint'(coord_x_i);
              poly_y[held] = longint'(coord_y_i);
              held++;
              fresh.code = RES_STORED;
            end
          end
          ACT_QUERY: begin
            fresh.code = locate_point(longint'(coord_x_i), longint'(coord_y_i));
          end
          default: begin
            fresh.code = RES_BOUNDARY;
          end
        endcase
        fresh.count = COUNT_OUT_W'(held);
        results_due.push_back(fresh);
      end
      pending_o <= results_due.size();
    end
  end

endmodule

// ===== test/tb_point_in_polygon_test.sv =====
// Testbench top for point_in_polygon_test: clock, reset, item stimulus and verdict.
// Depends on pipt_pkg, point_in_polygon_test and pipt_checker.
`timescale 1ns / 1ps

module tb_point_in_polygon_test;
  import pipt_pkg::*;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 16;
  localparam int ITEM_TARGET  = 2000;

  // The action code that the block leaves unused; it must still answer.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Ways of drawing coordinates for a polygon and its queries.
  typedef enum int {
    STYLE_GRID    = 0,  // small even grid, so edges meet query points often
    STYLE_FULL    = 1,  // any 16-bit value
    STYLE_EXTREME = 2,  // values around zero and the two ends of the range
    STYLE_CORNER  = 3   // a small grid pushed out against the range limits
  } coord_style_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic [1:0]             action_i;
  coord_t                 coord_x_i;
  coord_t                 coord_y_i;
  logic                   done_o;
  logic [2:0]             result_code_o;
  logic [COUNT_OUT_W-1:0] vertex_count_o;

  int mismatch_count;
  int pending;

  // Shadow of the vertices handed to the block, used only to aim queries at
  // vertices and edges of the current polygon.
  coord_t shadow_x[$];
  coord_t shadow_y[$];

  int items_sent = 0;
  bit no_idle    = 1'b0;

  point_in_polygon_test #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .done_o         (done_o),
    .result_code_o  (result_code_o),
    .vertex_count_o (vertex_count_o)
  );

  pipt_checker #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .action_i         (action_i),
    .coord_x_i        (coord_x_i),
    .coord_y_i        (coord_y_i),
    .done_i           (done_o),
    .result_code_i    (result_code_o),
    .vertex_count_i   (vertex_count_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Idle gap before an item: mostly none or a few cycles, now and then a long
  // one, and none at all while a burst is running.
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  function automatic coord_t rand_coord(input coord_style_e style);
    int magnitude;
    case (style)
      STYLE_GRID: begin
        return coord_t'(2 * int'($urandom_range(0, 16)) - 16);
      end
      STYLE_EXTREME: begin
        case ($urandom_range(0, 6))
          0:       return coord_t'(-32768);
          1:       return coord_t'(-32767);
          2:       return coord_t'(-1);
          3:       return coord_t'(0);
          4:       return coord_t'(1);
          5:       return coord_t'(32766);
          default: return coord_t'(32767);
        endcase
      end
      STYLE_CORNER: begin
        magnitude = 32767 - 2 * int'($urandom_range(0, 8));
        return $urandom_range(0, 1) ? coord_t'(magnitude) : coord_t'(-magnitude - 1);
      end
      default: begin
        return coord_t'($urandom);
      end
    endcase
  endfunction

  // Query points: a vertex, the middle of an edge, a near miss next to a
  // vertex, or a free point drawn the same way as the vertices.
  task automatic pick_query(input coord_style_e style, output coord_t qx, output coord_t qy);
    int n, roll, a, b;
    n    = shadow_x.size();
    roll = $urandom_range(0, 99);
    if (n > 0) a = $urandom_range(0, n - 1);
    else a = 0;
    b = (n > 0) ? (a + 1) % n : 0;
    if (n > 0 && roll < 20) begin
      qx = shadow_x[a];
      qy = shadow_y[a];
    end else if (n > 1 && roll < 40) begin
      qx = coord_t'((int'(shadow_x[a]) + int'(shadow_x[b])) >>> 1);
      qy = coord_t'((int'(shadow_y[a]) + int'(shadow_y[b])) >>> 1);
    end else if (n > 0 && roll < 50) begin
      qx = coord_t'(int'(shadow_x[a]) + int'($urandom_range(0, 2)) - 1);
      qy = coord_t'(int'(shadow_y[a]) + int'($urandom_range(0, 2)) - 1);
    end else begin
      qx = rand_coord(style);
      qy = rand_coord(style);
    end
  endtask

  // Offers one item and returns at the edge where it was taken. Start stays
  // high after the handshake so that a back-to-back item keeps it up; a gap
  // lowers it first.
  task automatic drive_item(input logic [1:0] act, input coord_t x, input coord_t y);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    action_i  <= act;
    coord_x_i <= x;
    coord_y_i <= y;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    case (act)
      ACT_CLEAR: begin
        shadow_x.delete();
        shadow_y.delete();
      end
      ACT_APPEND: begin
        if (shadow_x.size() < MAX_VERTICES) begin
          shadow_x.push_back(x);
          shadow_y.push_back(y);
        end
      end
      default: ;
    endcase
  endtask

  // Holds the sender off until every outstanding result has come back. Start
  // is lowered first so the block cannot take the last item again.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // A well-formed sequence: clear (usually), a run of appends, then queries
  // with the odd unused action mixed in. Sizes are mostly small; a few runs
  // fill the store and push past it.
  task automatic run_polygon();
    coord_style_e style;
    int           roll, count, queries;
    coord_t       qx, qy;
    roll = $urandom_range(0, 99);
    if (roll < 50) style = STYLE_GRID;
    else if (roll < 70) style = STYLE_FULL;
    else if (roll < 85) style = STYLE_EXTREME;
    else style = STYLE_CORNER;
    no_idle = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 9) != 0) begin
      drive_item(ACT_CLEAR, coord_t'($urandom), coord_t'($urandom));
    end
    roll = $urandom_range(0, 99);
    if (roll < 70) count = $urandom_range(3, 8);
    else if (roll < 92) count = $urandom_range(0, 2);
    else count = $urandom_range(MAX_VERTICES - 4, MAX_VERTICES + 4);
    repeat (count) drive_item(ACT_APPEND, rand_coord(style), rand_coord(style));
    queries = $urandom_range(2, 8);
    repeat (queries) begin
      if ($urandom_range(0, 19) == 0) begin
        drive_item(ACT_UNUSED, coord_t'($urandom), coord_t'($urandom));
      end else begin
        pick_query(style, qx, qy);
        drive_item(ACT_QUERY, qx, qy);
      end
    end
    no_idle = 1'b0;
  endtask

  // Noise: any action with any coordinates, which also breaks up polygons
  // half way through.
  task automatic run_noise();
    repeat ($urandom_range(1, 6)) begin
      drive_item(2'($urandom_range(0, 3)), coord_t'($urandom), coord_t'($urandom));
    end
  endtask

  initial begin
    rst_ni    = 1'b0;
    start     = 1'b0;
    action_i  = ACT_CLEAR;
    coord_x_i = '0;
    coord_y_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. An empty store answers boundary, as does the unused action.
    drive_item(ACT_QUERY, coord_t'(0), coord_t'(0));
    drive_item(ACT_UNUSED, coord_t'(-32768), coord_t'(32767));
    // A triangle spanning the whole coordinate range; with two vertices a
    // query is still degenerate.
    drive_item(ACT_APPEND, coord_t'(-32768), coord_t'(-32768));
    drive_item(ACT_APPEND, coord_t'(32767), coord_t'(-32768));
    drive_item(ACT_QUERY, coord_t'(0), coord_t'(0));
    drive_item(ACT_APPEND, coord_t'(32767), coord_t'(32767));
    // On a vertex, on the bottom edge, on the closing diagonal, inside,
    // outside, on the right edge and at the far corner.
    drive_item(ACT_QUERY, coord_t'(32767), coord_t'(-32768));
    drive_item(ACT_QUERY, coord_t'(0), coord_t'(-32768));
    drive_item(ACT_QUERY, coord_t'(0), coord_t'(0));
    drive_item(ACT_QUERY, coord_t'(16000), coord_t'(-100));
    drive_item(ACT_QUERY, coord_t'(-100), coord_t'(16000));
    drive_item(ACT_QUERY, coord_t'(32767), coord_t'(0));
    drive_item(ACT_QUERY, coord_t'(-32768), coord_t'(32767));
    // A repeated vertex makes a zero-length edge, which must not change the answer.
    drive_item(ACT_APPEND, coord_t'(32767), coord_t'(32767));
    drive_item(ACT_QUERY, coord_t'(16000), coord_t'(-100));
    drive_item(ACT_QUERY, coord_t'(32767), coord_t'(32767));
    // Clear drops the count only; a query right after is degenerate again.
    drive_item(ACT_CLEAR, coord_t'(32767), coord_t'(-32768));
    drive_item(ACT_QUERY, coord_t'(0), coord_t'(0));
    // A small square around the origin.
    drive_item(ACT_APPEND, coord_t'(-4), coord_t'(-4));
    drive_item(ACT_APPEND, coord_t'(4), coord_t'(-4));
    drive_item(ACT_APPEND, coord_t'(4), coord_t'(4));
    drive_item(ACT_APPEND, coord_t'(-4), coord_t'(4));
    drive_item(ACT_QUERY, coord_t'(0), coord_t'(0));
    drive_item(ACT_QUERY, coord_t'(-4), coord_t'(0));
    drive_item(ACT_QUERY, coord_t'(5), coord_t'(0));
    drive_item(ACT_UNUSED, coord_t'(0), coord_t'(0));

    // Let everything come back once before the random part.
    wait_drained();

    // Fill the store and go past it, so a full store is seen early and a
    // query walks all the cells with real edges.
    drive_item(ACT_CLEAR, coord_t'($urandom), coord_t'($urandom));
    repeat (MAX_VERTICES + 2) begin
      drive_item(ACT_APPEND, rand_coord(STYLE_GRID), rand_coord(STYLE_GRID));
    end
    drive_item(ACT_QUERY, coord_t'(0), coord_t'(0));
    drive_item(ACT_QUERY, coord_t'(1), coord_t'(-1));

    // Random part: mostly well-formed polygons with random content, the rest
    // noise, with a drain pause now and then.
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 80) run_polygon();
      else run_noise();
      if ($urandom_range(0, 19) == 0) wait_drained();
    end

    // Drain, then give the block a full query time to show any stray result.
    wait_drained();
    repeat (MAX_VERTICES + 8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("tb_point_in_polygon_test: PASS");
    end else begin
      $display("tb_point_in_polygon_test: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, even with every item a full
  // query behind the longest idle gap.
  initial begin
    #30ms;
    $display("tb_point_in_polygon_test: FAIL");
    $finish;
  end

endmodule
